// ----- design/fhpa_pkg.sv -----
`timescale 1ns / 1ps

package fhpa_pkg;

	// Default pool size and fixed field widths
	localparam int POOL_SIZE_DEF = 16;
	localparam int HANDLE_W      = 4;
	localparam int FUNC_W        = 2;
	localparam int STATUS_W      = 2;

	// Request codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC   = 2'd0,
		FUNC_TRY     = 2'd1,
		FUNC_RELEASE = 2'd2
	} func_e_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_INVALID   = 2'd2,
		STAT_EXHAUSTED = 2'd3
	} status_e_t;

	// Control sequencer states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [HANDLE_W-1:0] handle_in;
	} in_item_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		logic [STATUS_W-1:0] status;
	} out_item_t;

endpackage

// ----- design/fifo_handle_pool_allocator.sv -----
`timescale 1ns / 1ps

// Handle pool allocator.
// Requests come in on in_valid/in_ready with in_data (func, handle_in); one
// result per request leaves on out_valid/out_ready with out_data
// (handle_out, status). Allocate pops the oldest released handle, else
// grants the next never-used handle, else reports exhausted. Try-allocate
// only pops. Release checks the in-use bit and pushes the handle to the back
// of the released-handle queue.
// A request's result is written to the output register by its execute
// step; a new request is taken only once the previous one has executed.
// The released-handle queue and the in-use bitmap sit in synchronous RAMs,
// read in the transfer cycle and written back in the execute step.
// A new request is taken while a previous result still waits at the output;
// if the receiver stalls, the execute step holds until the output register
// frees up, and in_ready stays low meanwhile.
// Reset clears head, tail, count and the fresh-handle counter; no RAM
// clearing pass is needed, since bitmap entries at or above the fresh
// counter are treated as not in use.
module fifo_handle_pool_allocator
	import fhpa_pkg::*;
#(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int HW = $clog2(POOL_SIZE);
	localparam int CW = $clog2(POOL_SIZE + 1);
	localparam int XW = (CW > HANDLE_W) ? CW : HANDLE_W;

	state_t state_q, state_d;

	logic [HW-1:0]       head_q, tail_q;
	logic [CW-1:0]       count_q, fresh_q;
	logic [FUNC_W-1:0]   func_s1;
	logic [HANDLE_W-1:0] hin_s1;
	logic                out_valid_q;
	out_item_t           out_data_q;

	logic          in_fire, exec_fire;
	logic [XW-1:0] hin_acc_x, hin_x, fresh_x, hsel_x;
	logic [HW-1:0] map_raddr, fifo_rdata;
	logic          map_rdata;

	// execute step decisions
	logic          do_pop, do_fresh, do_release;
	logic [HW-1:0] hsel;
	status_e_t     status_d;
	logic          in_use, q_nonempty, q_full, fresh_avail;
	logic          map_we, map_wdata;
	logic [HW-1:0] map_waddr;

	function automatic logic [HW-1:0] next_pos(input logic [HW-1:0] p);
		logic [HW-1:0] n;
		n = (p == HW'(POOL_SIZE - 1)) ? '0 : HW'(p + 1'b1);
		return n;
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_EXEC;
			S_EXEC: if (exec_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		exec_fire = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_EXEC: exec_fire = !out_valid_q || out_ready;
			default: begin
				in_ready  = 1'b0;
				exec_fire = 1'b0;
			end
		endcase
	end

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1 <= in_data.func;
			hin_s1  <= in_data.handle_in;
		end
	end

	// read addresses presented in the transfer cycle
	assign hin_acc_x = XW'(in_data.handle_in);
	assign map_raddr = hin_acc_x[HW-1:0];

	// released-handle queue storage
	fhpa_ram #(
		.DEPTH(POOL_SIZE),
		.WIDTH(HW)
	) u_fifo_ram (
		.clk  (clk),
		.we   (do_release),
		.waddr(tail_q),
		.wdata(hin_x[HW-1:0]),
		.re   (in_fire),
		.raddr(head_q),
		.rdata(fifo_rdata)
	);

	// in-use bitmap storage
	fhpa_ram #(
		.DEPTH(POOL_SIZE),
		.WIDTH(1)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.re   (in_fire),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	// execute: decide the operation from the read data
	assign hin_x       = XW'(hin_s1);
	assign fresh_x     = XW'(fresh_q);
	assign in_use      = (hin_x < fresh_x) && map_rdata;
	assign q_nonempty  = (count_q != '0);
	assign q_full      = (count_q == CW'(POOL_SIZE));
	assign fresh_avail = (fresh_q < CW'(POOL_SIZE));

	always_comb begin
		do_pop     = 1'b0;
		do_fresh   = 1'b0;
		do_release = 1'b0;
		status_d   = STAT_OK;
		unique case (func_s1)
			FUNC_ALLOC: begin
				if (q_nonempty) begin
					do_pop = exec_fire;
				end else if (fresh_avail) begin
					do_fresh = exec_fire;
				end else begin
					status_d = STAT_EXHAUSTED;
				end
			end
			FUNC_TRY: begin
				if (q_nonempty) begin
					do_pop = exec_fire;
				end else begin
					status_d = STAT_EMPTY;
				end
			end
			FUNC_RELEASE: begin
				if (!in_use || q_full) begin
					status_d = STAT_INVALID;
				end else begin
					do_release = exec_fire;
				end
			end
			default: status_d = STAT_INVALID;
		endcase
	end

	// granted handle; zero unless the request grants one
	always_comb begin
		hsel = '0;
		if (func_s1 == FUNC_ALLOC || func_s1 == FUNC_TRY) begin
			if (q_nonempty) begin
				hsel = fifo_rdata;
			end else if (func_s1 == FUNC_ALLOC && fresh_avail) begin
				hsel = fresh_q[HW-1:0];
			end
		end
	end
	assign hsel_x = XW'(hsel);

	// bitmap write-back
	always_comb begin
		map_we    = do_pop || do_fresh || do_release;
		map_wdata = !do_release;
		map_waddr = do_release ? hin_x[HW-1:0] : hsel;
	end

	// queue pointers and fresh counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
		end else begin
			if (do_pop) begin
				head_q  <= next_pos(head_q);
				count_q <= count_q - 1'b1;
			end
			if (do_release) begin
				tail_q  <= next_pos(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (do_fresh) begin
				fresh_q <= fresh_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			out_data_q.handle_out <= hsel_x[HANDLE_W-1:0];
			out_data_q.status     <= status_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- design/fhpa_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port synchronous RAM, one write and one registered read port
module fhpa_ram
	import fhpa_pkg::*;
#(
	parameter int DEPTH = POOL_SIZE_DEF,
	parameter int WIDTH = HANDLE_W,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/fhpa_chk.sv -----
`timescale 1ns / 1ps

// Port-level checks for the handle pool allocator
module fhpa_chk
	import fhpa_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	logic [2:0] pending_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// requests taken but results not yet transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	// at most one request executing and one result waiting
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more than two requests outstanding");

	// no result without a request behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result shown with no request outstanding");

	// one request at a time: ready drops after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("request taken while previous one executes");

	// failed requests carry a zero handle
	a_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STAT_OK |-> out_data.handle_out == '0)
		else $error("nonzero handle on failed request");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

endmodule

bind fifo_handle_pool_allocator fhpa_chk u_fhpa_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
